@@ src/sdtq_pkg.sv @@
// Shared types, codes and helpers for the sorted delay timer queue.
package sdtq_pkg;

  // Width of the tick counter and of every deadline.
  localparam int TICK_W = 32;
  // Width of the task field on the ports.
  localparam int PORT_TASK_W = 8;
  // Most wakes that one tick may release.
  localparam int MAX_WAKES = 32;
  // Wake counter width, wide enough to hold MAX_WAKES itself.
  localparam int WAKE_CNT_W = 6;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_DELAY = 2'd1,
    REQ_UNTIL = 2'd2,
    REQ_TIME  = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    RPL_OK      = 2'd0,
    RPL_NOSPACE = 2'd1,
    RPL_WAKE    = 2'd2,
    RPL_TIME    = 2'd3
  } reply_kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic        latch;
    logic        decode;
    logic        reply;
    reply_kind_t reply_kind;
    logic        tk_take;
    logic        wake;
    logic        wake_last;
    logic        ins_start;
    logic        ins_shift;
    logic        ins_put;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    req_type_t req;
    logic      empty;
    logic      full;
    logic      reached;
    logic      due;
    logic      ins_stop;
    logic      out_free;
  } dp_stat_t;

  // Signed less-or-equal on two tick values.
  function automatic logic sle_tick(input logic [TICK_W-1:0] a, input logic [TICK_W-1:0] b);
    return $signed(a) <= $signed(b);
  endfunction

endpackage

@@ src/sdtq_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module sdtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/sdtq_ctrl.sv @@
// Controller state machine for the sorted delay timer queue.
module sdtq_ctrl
  import sdtq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_DECODE   = 7'b0000010,
    S_CHECK    = 7'b0000100,
    S_REPLY    = 7'b0001000,
    S_TK_FIRST = 7'b0010000,
    S_TK_NEXT  = 7'b0100000,
    S_INS      = 7'b1000000
  } state_t;

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        case (stat.req)
          REQ_TICK: state_next = stat.empty ? S_IDLE : S_TK_FIRST;
          REQ_TIME: state_next = S_REPLY;
          default:  state_next = S_CHECK;
        endcase
      end
      S_CHECK: begin
        if (stat.reached || stat.full) begin
          state_next = S_REPLY;
        end else begin
          cmd.ins_start = 1'b1;
          state_next    = S_INS;
        end
      end
      S_REPLY: begin
        if (stat.req == REQ_TIME) begin
          cmd.reply_kind = RPL_TIME;
        end else if (stat.reached) begin
          cmd.reply_kind = RPL_OK;
        end else begin
          cmd.reply_kind = RPL_NOSPACE;
        end
        if (stat.out_free) begin
          cmd.reply  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_TK_FIRST: begin
        // The head entry is held back until we know whether it is the last wake.
        if (stat.due) begin
          cmd.tk_take = 1'b1;
          state_next  = S_TK_NEXT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_TK_NEXT: begin
        if (stat.out_free) begin
          cmd.wake      = 1'b1;
          cmd.wake_last = !stat.due;
          if (stat.due) begin
            cmd.tk_take = 1'b1;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_INS: begin
        // Walk back from the tail, moving later deadlines up by one slot.
        if (stat.ins_stop) begin
          cmd.ins_put = 1'b1;
          state_next  = S_IDLE;
        end else begin
          cmd.ins_shift = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ src/sdtq_dp.sv @@
// Datapath: tick counter, ring-buffer wait queue, request and result registers.
module sdtq_dp
  import sdtq_pkg::*;
#(
  parameter int QUEUE_DEPTH  = 32,
  parameter int TASK_ID_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [1:0]                    req_type,
  input  logic [PORT_TASK_W-1:0]        task_id,
  input  logic signed [TICK_W-1:0]      tick_amount,
  input  dp_cmd_t                       cmd,
  output dp_stat_t                      stat,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    reply_kind,
  output logic [PORT_TASK_W-1:0]        reply_task,
  output logic signed [TICK_W-1:0]      reply_value,
  output logic                          last
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int TID_W = (TASK_ID_BITS < PORT_TASK_W) ? TASK_ID_BITS : PORT_TASK_W;
  localparam int ENT_W = TICK_W + TID_W;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(QUEUE_DEPTH - 1) : p - 1'b1;
  endfunction

  // Control state.
  logic [TICK_W-1:0]     now_ticks;
  logic [PTR_W-1:0]      head;
  logic [PTR_W-1:0]      tail;
  logic [CNT_W-1:0]      count;
  logic [WAKE_CNT_W-1:0] n_wakes;

  // Request and work registers.
  req_type_t          req;
  logic [TID_W-1:0]   req_task;
  logic [TICK_W-1:0]  req_amount;
  logic [TICK_W-1:0]  deadline;
  logic [TID_W-1:0]   held_task;
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W-1:0]   wr_ptr;
  logic [CNT_W-1:0]   steps;

  // Result register.
  logic [1:0]             out_kind;
  logic [PORT_TASK_W-1:0] out_task;
  logic [TICK_W-1:0]      out_value;
  logic                   out_last;
  logic                   out_free;

  // Queue memory.
  logic              ram_we;
  logic [PTR_W-1:0]  ram_waddr;
  logic [ENT_W-1:0]  ram_wdata;
  logic [PTR_W-1:0]  ram_raddr;
  logic [ENT_W-1:0]  ram_rdata;
  logic [TICK_W-1:0] rd_dl;
  logic [TID_W-1:0]  rd_task;

  assign rd_dl   = ram_rdata[TID_W +: TICK_W];
  assign rd_task = ram_rdata[TID_W-1:0];

  // Read address is set ahead so the registered read data matches the pointer in use.
  always_comb begin
    if (cmd.ins_start) begin
      ram_raddr = ptr_dec(tail);
    end else if (cmd.ins_shift) begin
      ram_raddr = ptr_dec(rd_ptr);
    end else if (cmd.tk_take) begin
      ram_raddr = ptr_inc(head);
    end else begin
      ram_raddr = head;
    end
  end

  assign ram_we    = cmd.ins_shift | cmd.ins_put;
  assign ram_waddr = wr_ptr;
  assign ram_wdata = cmd.ins_put ? {deadline, req_task} : ram_rdata;

  sdtq_ram #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Status to the controller.
  assign out_free      = !out_valid || out_ready;
  assign stat.req      = req;
  assign stat.empty    = (count == '0);
  assign stat.full     = (count == CNT_W'(QUEUE_DEPTH));
  assign stat.reached  = sle_tick(deadline, now_ticks);
  assign stat.due      = (count != '0) && (n_wakes < WAKE_CNT_W'(MAX_WAKES)) &&
                         sle_tick(rd_dl, now_ticks);
  assign stat.ins_stop = (steps == '0) || sle_tick(rd_dl, deadline);
  assign stat.out_free = out_free;

  // Counter, queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      now_ticks <= '0;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      n_wakes   <= '0;
    end else begin
      if (cmd.decode && req == REQ_TICK) begin
        now_ticks <= now_ticks + 1'b1;
      end
      if (cmd.decode) begin
        n_wakes <= '0;
      end else if (cmd.tk_take) begin
        n_wakes <= n_wakes + 1'b1;
      end
      if (cmd.tk_take) begin
        head  <= ptr_inc(head);
        count <= count - 1'b1;
      end else if (cmd.ins_put) begin
        tail  <= ptr_inc(tail);
        count <= count + 1'b1;
      end
    end
  end

  // Request capture, deadline and insertion walk.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req        <= req_type_t'(req_type);
      req_task   <= task_id[TID_W-1:0];
      req_amount <= tick_amount;
    end
    if (cmd.decode) begin
      deadline <= (req == REQ_DELAY) ? req_amount + now_ticks : req_amount;
    end
    if (cmd.tk_take) begin
      held_task <= rd_task;
    end
    if (cmd.ins_start) begin
      rd_ptr <= ptr_dec(tail);
      wr_ptr <= tail;
      steps  <= count;
    end else if (cmd.ins_shift) begin
      rd_ptr <= ptr_dec(rd_ptr);
      wr_ptr <= rd_ptr;
      steps  <= steps - 1'b1;
    end
  end

  // Result register: loads whenever the previous beat is gone or leaving.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.reply || cmd.wake) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wake) begin
      out_kind  <= RPL_WAKE;
      out_task  <= PORT_TASK_W'(held_task);
      out_value <= now_ticks;
      out_last  <= cmd.wake_last;
    end else if (cmd.reply) begin
      out_kind  <= cmd.reply_kind;
      out_task  <= PORT_TASK_W'(req_task);
      out_value <= (cmd.reply_kind == RPL_TIME) ? now_ticks : '0;
      out_last  <= 1'b1;
    end
  end

  assign reply_kind  = out_kind;
  assign reply_task  = out_task;
  assign reply_value = out_value;
  assign last        = out_last;

  // The fill count never passes the queue depth.
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue fill count above depth");

  // An insert only lands when there is room.
  a_put_room : assert property (@(posedge clk) disable iff (rst)
    cmd.ins_put |-> (count < CNT_W'(QUEUE_DEPTH)))
    else $error("insert into a full queue");

  // An empty queue has head and tail together.
  a_empty_ptrs : assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (head == tail))
    else $error("pointers apart on an empty queue");

  // A new result never overwrites one still waiting.
  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    (cmd.reply || cmd.wake) |-> out_free)
    else $error("result register overwritten");

  // One tick releases no more than the wake limit.
  a_wake_limit : assert property (@(posedge clk) disable iff (rst)
    n_wakes <= WAKE_CNT_W'(MAX_WAKES))
    else $error("too many wakes on one tick");

endmodule

@@ src/sorted_delay_timer_queue.sv @@
// Top level of the sorted delay timer queue: controller plus datapath.
// Time reply: decode then reply state; ok and out-of-space also pass a check state.
// Tick: decode, head check, then each woken task as the result frees (up to 32 per tick).
// Delay insert: decode, check, a shift per later entry, then a put, via one RAM port pair.
// One request is worked at a time; the next beat is taken the cycle after, even if a result waits.
// Reset clears the tick count, queue pointers and fill count; the queue RAM needs no clearing.
module sorted_delay_timer_queue
  import sdtq_pkg::*;
#(
  parameter int QUEUE_DEPTH  = 32,
  parameter int TASK_ID_BITS = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               req_type,
  input  logic [PORT_TASK_W-1:0]   task_id,
  input  logic signed [TICK_W-1:0] tick_amount,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               reply_kind,
  output logic [PORT_TASK_W-1:0]   reply_task,
  output logic signed [TICK_W-1:0] reply_value,
  output logic                     last
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sdtq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sdtq_dp #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .TASK_ID_BITS (TASK_ID_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .req_type    (req_type),
    .task_id     (task_id),
    .tick_amount (tick_amount),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .reply_kind  (reply_kind),
    .reply_task  (reply_task),
    .reply_value (reply_value),
    .last        (last)
  );

endmodule

@@ tb/sdtq_checker.sv @@
// Checker for the sorted delay timer queue: predicts every reply and compares it.
module sdtq_checker
  import sdtq_pkg::*;
#(
  parameter int QUEUE_DEPTH  = 32,
  parameter int TASK_ID_BITS = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [1:0]               req_type,
  input  logic [PORT_TASK_W-1:0]   task_id,
  input  logic signed [TICK_W-1:0] tick_amount,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [1:0]               reply_kind,
  input  logic [PORT_TASK_W-1:0]   reply_task,
  input  logic signed [TICK_W-1:0] reply_value,
  input  logic                     last,
  output int                       errors,
  output int                       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    reply_kind_t            kind;
    logic [PORT_TASK_W-1:0] who;
    logic [TICK_W-1:0]      value;
    logic                   fin;
  } reply_t;

  // Predicted timer state: the tick count and the deadline-sorted wait list.
  logic [TICK_W-1:0]      tick_now;
  logic [TICK_W-1:0]      park_deadline [QUEUE_DEPTH];
  logic [PORT_TASK_W-1:0] park_task [QUEUE_DEPTH];
  int                     park_count;

  // Replies predicted but not yet seen on the output channel, oldest first.
  reply_t owed_replies[$];

  initial errors = 0;

  // Signed a <= b, done as an unsigned compare on offset-binary values.
  function automatic logic not_later(input logic [TICK_W-1:0] a, input logic [TICK_W-1:0] b);
    return (a ^ {1'b1, {(TICK_W-1){1'b0}}}) <= (b ^ {1'b1, {(TICK_W-1){1'b0}}});
  endfunction

  function automatic void owe(input reply_kind_t kind, input logic [PORT_TASK_W-1:0] who,
                              input logic [TICK_W-1:0] value, input logic fin);
    reply_t r;
    r.kind  = kind;
    r.who   = who;
    r.value = value;
    r.fin   = fin;
    owed_replies.push_back(r);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns  mismatch: %s", $time, msg);
    errors++;
  endtask

  // Work out the replies for one accepted request and update the timer state.
  task automatic apply_request(input logic [1:0] kind, input logic [PORT_TASK_W-1:0] who_in,
                               input logic [TICK_W-1:0] amount);
    logic [PORT_TASK_W-1:0] who;
    logic [TICK_W-1:0]      target;
    int                     n;
    int                     pos;
    int                     i;
    who = who_in & PORT_TASK_W'((1 << TASK_ID_BITS) - 1);
    case (kind)
      REQ_TICK: begin
        tick_now = tick_now + 1'b1;
        n = 0;
        while (n < park_count && n < MAX_WAKES && not_later(park_deadline[n], tick_now))
          n++;
        for (i = 0; i < n; i++)
          owe(RPL_WAKE, park_task[i], tick_now, i == n - 1);
        for (i = n; i < park_count; i++) begin
          park_deadline[i - n] = park_deadline[i];
          park_task[i - n]     = park_task[i];
        end
        park_count -= n;
      end
      REQ_TIME: owe(RPL_TIME, who, tick_now, 1'b1);
      default: begin
        target = (kind == REQ_DELAY) ? amount + tick_now : amount;
        if (not_later(target, tick_now)) begin
          owe(RPL_OK, who, '0, 1'b1);
        end else if (park_count >= QUEUE_DEPTH) begin
          owe(RPL_NOSPACE, who, '0, 1'b1);
        end else begin
          // Stable insert: after every entry due no later than this one.
          pos = 0;
          while (pos < park_count && not_later(park_deadline[pos], target))
            pos++;
          for (i = park_count; i > pos; i--) begin
            park_deadline[i] = park_deadline[i - 1];
            park_task[i]     = park_task[i - 1];
          end
          park_deadline[pos] = target;
          park_task[pos]     = who;
          park_count++;
        end
      end
    endcase
  endtask

  // Compare one reply beat against the oldest prediction.
  task automatic check_reply();
    reply_t want;
    if (owed_replies.size() == 0) begin
      report_mismatch($sformatf("reply with none owed: kind %0d task %0h value %0h last %0b",
                                reply_kind, reply_task, reply_value, last));
    end else begin
      want = owed_replies.pop_front();
      if (reply_kind !== want.kind)
        report_mismatch($sformatf("reply_kind got %0d want %0d", reply_kind, want.kind));
      if (reply_task !== want.who)
        report_mismatch($sformatf("reply_task got %0h want %0h", reply_task, want.who));
      if (reply_value !== want.value)
        report_mismatch($sformatf("reply_value got %0h want %0h", reply_value, want.value));
      if (last !== want.fin)
        report_mismatch($sformatf("last got %0b want %0b", last, want.fin));
    end
  endtask

  // Watch both channels; the request side is handled first on each edge.
  always @(posedge clk) begin
    if (rst) begin
      tick_now   = '0;
      park_count = 0;
      owed_replies.delete();
    end else begin
      if (in_valid && in_ready)
        apply_request(req_type, task_id, tick_amount);
      if (out_valid && out_ready)
        check_reply();
    end
    pending = owed_replies.size();
  end

endmodule

@@ tb/tb.sv @@
// Testbench top for the sorted delay timer queue: stimulus, back-pressure and verdict.
module tb
  import sdtq_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles after the last reply that a queue insert may still be busy.
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int ITEM_TARGET   = 420;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [1:0]               req_type = REQ_TICK;
  logic [PORT_TASK_W-1:0]   task_id = '0;
  logic signed [TICK_W-1:0] tick_amount = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [1:0]               reply_kind;
  logic [PORT_TASK_W-1:0]   reply_task;
  logic signed [TICK_W-1:0] reply_value;
  logic                     last;
  int                       errors;
  int                       pending;

  // Stimulus control; steady and hold_req are shared with the receiver process.
  bit                steady   = 1'b0;
  bit                hold_req = 1'b0;
  int                next_gap = 0;
  int                items_sent = 0;
  logic [TICK_W-1:0] now_est = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sorted_delay_timer_queue u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .task_id     (task_id),
    .tick_amount (tick_amount),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .reply_kind  (reply_kind),
    .reply_task  (reply_task),
    .reply_value (reply_value),
    .last        (last)
  );

  sdtq_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .task_id     (task_id),
    .tick_amount (tick_amount),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .reply_kind  (reply_kind),
    .reply_task  (reply_task),
    .reply_value (reply_value),
    .last        (last),
    .errors      (errors),
    .pending     (pending)
  );

  // Mostly back-to-back, sometimes a short gap, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one request beat and hold it until it is taken.
  task automatic send_req(input req_type_t kind, input logic [PORT_TASK_W-1:0] who,
                          input logic [TICK_W-1:0] amount);
    repeat (next_gap) @(posedge clk);
    in_valid    <= 1'b1;
    req_type    <= kind;
    task_id     <= who;
    tick_amount <= amount;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (kind == REQ_TICK) now_est = now_est + 1'b1;
    next_gap = steady ? 0 : pick_gap();
    if (next_gap > 0) in_valid <= 1'b0;
  endtask

  // Stop offering, wait for every owed reply, then let a pending insert finish.
  task automatic pause_until_drained();
    if (next_gap == 0) in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Receiver: random stalls, no stalls in steady stretches, one long hold-off on request.
  initial begin
    int r;
    int n;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (steady) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_ready <= 1'b1;
          n = $urandom_range(1, 12);
        end else if (r < 92) begin
          out_ready <= 1'b0;
          n = $urandom_range(1, 3);
        end else begin
          out_ready <= 1'b0;
          n = $urandom_range(10, 40);
        end
        repeat (n) @(posedge clk);
      end
    end
  end

  // Request stream: directed corners, then random sequences, then the verdict.
  initial begin
    int                n;
    int                k;
    int                pick;
    int                waited;
    bit                first;
    bit                same;
    bit                held;
    logic [TICK_W-1:0] base;
    logic [TICK_W-1:0] amount;
    req_type_t         kind;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reached deadlines at the field extremes, stable order on equal deadlines.
    send_req(REQ_TIME,  8'h00, 32'h0000_0000);
    send_req(REQ_TICK,  8'h01, 32'h0000_0000);
    send_req(REQ_DELAY, 8'h02, 32'h0000_0000);
    send_req(REQ_DELAY, 8'h03, 32'hFFFF_FFFF);
    send_req(REQ_DELAY, 8'h04, 32'h7FFF_FFFF);  // wraps to a negative deadline
    send_req(REQ_DELAY, 8'h05, 32'h8000_0000);
    send_req(REQ_UNTIL, 8'h06, 32'h0000_0000);
    send_req(REQ_UNTIL, 8'h07, 32'h8000_0000);
    send_req(REQ_UNTIL, 8'h08, 32'h0000_0001);  // deadline equal to the count
    send_req(REQ_DELAY, 8'hFF, 32'h0000_0001);
    send_req(REQ_DELAY, 8'h00, 32'h0000_0001);
    send_req(REQ_DELAY, 8'hAA, 32'h0000_0003);
    send_req(REQ_UNTIL, 8'h55, 32'h0000_0002);
    send_req(REQ_TIME,  8'hFF, 32'hFFFF_FFFF);
    send_req(REQ_TICK,  8'h7E, 32'h5A5A_A5A5);  // three wakes in arrival order
    send_req(REQ_TICK,  8'h81, 32'h0000_0000);
    send_req(REQ_TICK,  8'h3C, 32'hFFFF_FFFF);
    send_req(REQ_TIME,  8'hC3, 32'h0000_0000);
    pause_until_drained();

    // Random sequences; the first one fills an empty queue with one deadline.
    first = 1'b1;
    held  = 1'b0;
    while (items_sent < ITEM_TARGET) begin
      steady = (items_sent >= 100 && items_sent < 150);
      pick = first ? 0 : $urandom_range(1, 99);
      if (!held && items_sent > 220) begin
        // Long receiver hold-off while requests keep coming.
        held     = 1'b1;
        hold_req = 1'b1;
        steady   = 1'b1;
        for (k = 0; k < 12; k++)
          send_req(REQ_TIME, PORT_TASK_W'($urandom), $urandom);
        steady = 1'b0;
        pause_until_drained();
      end else if (pick < 6) begin
        // Fill past capacity, then tick the queue empty again.
        same = first ? 1'b1 : 1'($urandom_range(0, 1));
        base = $urandom_range(1, 6);
        for (k = 0; k < 36; k++) begin
          amount = same ? base : TICK_W'($urandom_range(1, 6));
          send_req(REQ_DELAY, PORT_TASK_W'($urandom), amount);
        end
        for (k = 0; k < 8; k++)
          send_req(REQ_TICK, PORT_TASK_W'($urandom), $urandom);
      end else if (pick < 40) begin
        // Short-horizon delays, relative and absolute, with frequent ties.
        n = $urandom_range(1, 12);
        for (k = 0; k < n; k++) begin
          if ($urandom_range(0, 1)) begin
            send_req(REQ_DELAY, PORT_TASK_W'($urandom), TICK_W'($urandom_range(1, 20)));
          end else begin
            amount = now_est + TICK_W'($urandom_range(0, 22)) - 32'd2;
            send_req(REQ_UNTIL, PORT_TASK_W'($urandom), amount);
          end
        end
      end else if (pick < 75) begin
        n = $urandom_range(1, 16);
        for (k = 0; k < n; k++)
          send_req(REQ_TICK, PORT_TASK_W'($urandom), $urandom);
      end else if (pick < 85) begin
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++)
          send_req(REQ_TIME, PORT_TASK_W'($urandom), $urandom);
      end else if (pick < 97) begin
        // Noise: any request, mostly far-past amounts, rarely a far-future park.
        n = $urandom_range(1, 6);
        for (k = 0; k < n; k++) begin
          kind = req_type_t'($urandom_range(0, 3));
          k = k;
          pick = $urandom_range(0, 99);
          if (pick < 70)      amount = $urandom | 32'h8000_0000;
          else if (pick < 95) amount = TICK_W'($urandom_range(0, 30));
          else                amount = $urandom;
          send_req(kind, PORT_TASK_W'($urandom), amount);
        end
      end else begin
        pause_until_drained();
      end
      first = 1'b0;
    end

    // Drain everything still owed, with a bound, then settle.
    steady = 1'b0;
    if (next_gap == 0) in_valid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending != 0 && waited < 50000);
    repeat (100) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #30000000;
    $display("tb: errors");
    $finish;
  end

endmodule

@@ filelist.f @@
src/sdtq_pkg.sv
src/sdtq_ram.sv
src/sdtq_ctrl.sv
src/sdtq_dp.sv
src/sorted_delay_timer_queue.sv
tb/sdtq_checker.sv
tb/tb.sv
